[hw/rtl/triac_phase_angle_firing_top_assert.svh]
// Assertion macros for the triac phase-angle firing block
`ifndef TRIAC_PHASE_ANGLE_FIRING_TOP_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_FIRING_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TPAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tpaf_pkg.sv]
// Shared types and constants for the triac phase-angle firing block
package tpaf_pkg;

  localparam int IN_W   = 8;
  localparam int OUT_W  = 48;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_SYNC_TIMEOUT = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GATE_PULSE   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DELAY_PCT    = 2'd2;
  localparam logic [CFG_IW-1:0] REG_DOUBLE_EDGE  = 2'd3;

  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/tpaf_ctrl.sv]
// Sequencer for one tick: state update, frequency divide, result load
module tpaf_ctrl
  import tpaf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.skip) begin
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/tpaf_dp.sv]
// Datapath: config registers, zero-cross timing, firing phase, divider, output beat
module tpaf_dp
  import tpaf_pkg::*;
#(
  parameter int COUNTER_WIDTH  = 24,
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int PW   = CW + 8;
  localparam int NUMW = 20 + FREQ_FRAC_BITS;
  localparam int CNTW = $clog2(NUMW);
  localparam logic [NUMW-1:0] NUM  = NUMW'(64'd1000000 << FREQ_FRAC_BITS);
  localparam logic [PW-1:0]   MEGA = PW'(1000000);
  localparam logic [CW-1:0]   TSE_MAX = '1;

  localparam logic [1:0] PH_OFF   = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_PULSE = 2'd2;
  localparam logic [1:0] PH_ON    = 2'd3;

  // configuration
  logic [23:0] sync_timeout;
  logic [9:0]  gate_pulse;
  logic [7:0]  delay_pct;
  logic [7:0]  dbl_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_timeout <= 24'd100000;
      gate_pulse   <= 10'd100;
      delay_pct    <= 8'd100;
      dbl_thr      <= 8'd70;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_TIMEOUT: sync_timeout <= cfg_data;
        REG_GATE_PULSE:   gate_pulse   <= cfg_data[9:0];
        REG_DELAY_PCT:    delay_pct    <= cfg_data[7:0];
        REG_DOUBLE_EDGE:  dbl_thr      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // tick state
  logic          zc;
  logic [6:0]    power;
  logic [CW-1:0] tse, tse_inc, tse_next;
  logic          seen, seen_next;
  logic [CW-1:0] cap, cap_next;
  logic [1:0]    ph, ph_next;
  logic [15:0]   pcnt, pcnt_next;
  logic          gate_next, sync_next;
  logic          gate_r, sync_r;
  logic [14:0]   delay_prod;

  assign zc         = s_tdata[0];
  assign power      = s_tdata[7:1];
  assign tse_inc    = (tse != TSE_MAX) ? tse + 1'b1 : tse;
  assign delay_prod = (7'd100 - power) * delay_pct;

  always_comb begin
    tse_next  = tse_inc;
    seen_next = seen;
    cap_next  = cap;
    ph_next   = ph;
    pcnt_next = pcnt;
    gate_next = 1'b0;
    if (zc) begin
      if (seen) begin
        cap_next = tse_inc;
      end
      tse_next  = '0;
      seen_next = 1'b1;
      if (power == 7'd0) begin
        ph_next   = PH_OFF;
        pcnt_next = '0;
      end else if (power inside {[7'd1:7'd99]}) begin
        ph_next   = PH_WAIT;
        pcnt_next = 16'(delay_prod);
      end else begin
        ph_next   = PH_ON;
        pcnt_next = '0;
      end
    end else if (ph == PH_WAIT && pcnt != 16'd0) begin
      pcnt_next = pcnt - 1'b1;
    end
    if (ph_next == PH_WAIT && pcnt_next == 16'd0) begin
      ph_next   = PH_PULSE;
      pcnt_next = 16'(gate_pulse);
    end
    if (ph_next == PH_ON) begin
      gate_next = 1'b1;
    end else if (ph_next == PH_PULSE) begin
      if (pcnt_next != 16'd0) begin
        gate_next = 1'b1;
        pcnt_next = pcnt_next - 1'b1;
      end
      if (pcnt_next == 16'd0) begin
        ph_next = PH_OFF;
      end
    end
    sync_next = seen_next && (32'(tse_next) <= 32'(sync_timeout));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tse  <= '0;
      seen <= 1'b0;
      cap  <= '0;
      ph   <= PH_OFF;
      pcnt <= '0;
    end else if (cmd.accept) begin
      tse  <= tse_next;
      seen <= seen_next;
      cap  <= cap_next;
      ph   <= ph_next;
      pcnt <= pcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gate_r <= gate_next;
      sync_r <= sync_next;
    end
  end

  // restoring divider: NUM / cap, one quotient bit a cycle
  logic [PW-1:0]   thr_prod;
  logic            dbl;
  logic [CW-1:0]   rem;
  logic [NUMW-1:0] quo;
  logic [CNTW-1:0] cnt;
  logic [CW:0]     trial, diff;
  logic            ge;
  logic [NUMW-1:0] q_adj;
  logic [15:0]     freq;

  assign thr_prod = PW'(dbl_thr) * PW'(cap);
  assign trial    = {rem, quo[NUMW-1]};
  assign diff     = trial - {1'b0, cap};
  assign ge       = trial >= {1'b0, cap};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dbl <= MEGA > thr_prod;
      rem <= '0;
      quo <= NUM;
      cnt <= CNTW'(NUMW - 1);
    end else if (cmd.div_step) begin
      rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo <= {quo[NUMW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign q_adj = dbl ? (quo >> 1) : quo;
  assign freq  = (q_adj > NUMW'(16'hFFFF)) ? 16'hFFFF : q_adj[15:0];

  assign sts.skip     = !sync_r || (cap == '0);
  assign sts.div_last = (cnt == '0);
  assign sts.out_free = !m_tvalid || m_tready;

  // output beat register
  logic [31:0] cap_ext;
  assign cap_ext = 32'(cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {6'd0, (sts.skip ? 16'd0 : freq), cap_ext[23:0], sync_r, gate_r};
    end
  end

endmodule

[hw/rtl/triac_phase_angle_firing_top.sv]
// Triac phase-angle firing block with zero-cross sync: top level
// Input channel s_*: one beat per microsecond tick, carrying the zero-cross
// edge flag and the requested power. Output channel m_*: one beat per input
// beat with gate level, line sync, captured period and Q8.8 line frequency.
// Configuration: cfg_we/cfg_index/cfg_data write the sync timeout, gate pulse
// width, per-percent delay and double-edge threshold; write only while idle.
// Sequence: the beat is taken in the idle state; the next state checks line
// sync and period and, if both are present, registers the double-edge test
// and starts the divider, which resolves one quotient bit a cycle; the done
// state then loads the output register. Without sync or period the divide is
// skipped. A new beat is taken only after the previous result is loaded.
// Reset (synchronous, rst high): counters, phase and output valid clear and
// the config registers return to their defaults; no item is pending.
// Stall: a result waits in the output register; the next input beat is taken
// meanwhile, but its result waits in the sequencer until the register frees.
module triac_phase_angle_firing_top
  import tpaf_pkg::*;
#(
  parameter int COUNTER_WIDTH  = 24,
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // zero_cross[0], power_pct[7:1]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // gate_drive[0], line_sync[1],
                                       // line_period[25:2], line_frequency_q8[41:26]
);

  cmd_t cmd;
  sts_t sts;

  tpaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpaf_dp #(
    .COUNTER_WIDTH  (COUNTER_WIDTH),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`include "triac_phase_angle_firing_top_assert.svh"

`TPAF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
`TPAF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready, "pending beat overwritten")
`TPAF_ASSERT_NOW(a_accept_alone, cmd.accept, !cmd.div_step && !cmd.load_out, "accept overlaps work")

endmodule
